>>> sv/q2e_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// quaternion-to-Euler core. No dependencies.
`timescale 1ns / 1ps
package q2e_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int DEG_FRAC        = 20;
  localparam int TAB_LEN         = 24;
  localparam int NSTG   = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int CW     = 38;   // CORDIC x/y width
  localparam int ZW     = 32;   // angle accumulator width, degrees * 2^20
  localparam int SQ_STG = 31;   // one root bit per stage
  localparam int SQ_W   = 62;
  localparam int RAD_W  = 61;
  localparam int ROOT_W = 31;
  localparam int CORD_LAT = NSTG + 1;

  localparam logic [15:0] POLE_THR_RESET = 16'd32735;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_case_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } quat_in_t;

  typedef struct packed {
    logic [15:0] pitch_deg;
    logic [15:0] yaw_deg;
    logic [15:0] roll_deg;
    logic [1:0]  pole_case;
  } euler_out_t;

  // atan(2^-i) in degrees * 2^20
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0:  t = 32'sd47185920;
      1:  t = 32'sd27855475;
      2:  t = 32'sd14718068;
      3:  t = 32'sd7471121;
      4:  t = 32'sd3750058;
      5:  t = 32'sd1876857;
      6:  t = 32'sd938658;
      7:  t = 32'sd469357;
      8:  t = 32'sd234682;
      9:  t = 32'sd117342;
      10: t = 32'sd58671;
      11: t = 32'sd29335;
      12: t = 32'sd14668;
      13: t = 32'sd7334;
      14: t = 32'sd3667;
      15: t = 32'sd1833;
      16: t = 32'sd917;
      17: t = 32'sd458;
      18: t = 32'sd229;
      19: t = 32'sd115;
      20: t = 32'sd57;
      21: t = 32'sd29;
      22: t = 32'sd14;
      23: t = 32'sd7;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> sv/q2e_isqrt.sv
// Pipelined restoring integer square root, one root bit per stage.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
module q2e_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [q2e_pkg::RAD_W-1:0]  radicand,
  output logic                       out_valid,
  output logic [q2e_pkg::ROOT_W-1:0] root
);
  import q2e_pkg::*;

  logic [SQ_W-1:0] rem_q [SQ_STG+1];
  logic [SQ_W-1:0] res_q [SQ_STG+1];
  logic            vld_q [SQ_STG+1];

  assign rem_q[0] = SQ_W'(radicand);
  assign res_q[0] = '0;
  assign vld_q[0] = in_valid;

  for (genvar k = 0; k < SQ_STG; k++) begin : g_stg
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * k);
    logic [SQ_W-1:0] trial;
    logic            take;

    assign trial = res_q[k] + BIT;
    assign take  = rem_q[k] >= trial;

    // advance one root bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
      rem_q[k+1] <= take ? rem_q[k] - trial : rem_q[k];
      res_q[k+1] <= take ? (res_q[k] >> 1) + BIT : res_q[k] >> 1;
    end
  end

  assign out_valid = vld_q[SQ_STG];
  assign root      = res_q[SQ_STG][ROOT_W-1:0];

endmodule

>>> sv/q2e_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees * 2^20.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
module q2e_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [q2e_pkg::CW-1:0] vec_x,
  input  logic signed [q2e_pkg::CW-1:0] vec_y,
  output logic                          out_valid,
  output logic signed [q2e_pkg::ZW-1:0] angle
);
  import q2e_pkg::*;

  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180) <<< DEG_FRAC;

  logic signed [CW-1:0] x_q [NSTG+1];
  logic signed [CW-1:0] y_q [NSTG+1];
  logic signed [ZW-1:0] z_q [NSTG+1];
  logic                 v_q [NSTG+1];

  // fold the left half plane over, starting at +-180
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= in_valid;
    end
    if (vec_x < 0) begin
      x_q[0] <= -vec_x;
      y_q[0] <= -vec_y;
      z_q[0] <= (vec_y >= 0) ? HALF_TURN : -HALF_TURN;
    end else begin
      x_q[0] <= vec_x;
      y_q[0] <= vec_y;
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN = atan_deg(i);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    // rotate toward y = 0; hold when y is already zero
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
      if (y_q[i] > 0) begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + ATAN;
      end else if (y_q[i] < 0) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - ATAN;
      end else begin
        x_q[i+1] <= x_q[i];
        y_q[i+1] <= y_q[i];
        z_q[i+1] <= z_q[i];
      end
    end
  end

  assign out_valid = v_q[NSTG];
  assign angle     = z_q[NSTG];

endmodule

>>> sv/quaternion_to_euler_degrees_core.sv
// Quaternion to Euler angles (pitch, yaw, roll in degrees, Q9.7).
// Depends on q2e_pkg, q2e_isqrt and q2e_cordic.
//
// Usage: drive quat and raise start; the word is taken at every rising
// edge with start high, and busy is always low, so a new quaternion may
// enter in every cycle. The result word appears on result with done high
// for exactly one cycle, after a capture register, the product, sum,
// threshold multiply and pole compare stages, the square root stages
// (one root bit per stage) for the arcsine cosine term, one CORDIC prep
// stage, one stage per CORDIC iteration, and the output register.
// Throughput is one word per cycle. The receiver cannot stall; results
// are never held.
// pole_threshold is written through cfg_valid/cfg_data (cfg_ready is
// always high) and must only change while no word is in flight.
// Reset (synchronous rst) empties the pipeline and restores the
// threshold to 32735.
`timescale 1ns / 1ps
module quaternion_to_euler_degrees_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  q2e_pkg::quat_in_t    quat,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  output logic                 done,
  output q2e_pkg::euler_out_t  result
);
  import q2e_pkg::*;

  localparam logic signed [CW-1:0] ONE_Q30 = CW'(1) <<< 30;
  localparam logic signed [33:0]   S_MAX   = 34'(1) <<< 30;
  localparam int RS   = DEG_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ZW+1:0] RHALF   = (ZW+2)'(1) <<< (RS - 1);
  localparam logic signed [ZW+1:0] FULL    = (ZW+2)'(360) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW+1:0] RIGHT   = (ZW+2)'(90) <<< DEG_FRAC;

  typedef struct packed {
    pole_case_t           pcase;
    logic signed [31:0]   s;
    logic signed [CW-1:0] half_x;
    logic signed [CW-1:0] half_y;
    logic signed [CW-1:0] yaw_x;
    logic signed [CW-1:0] yaw_y;
    logic signed [CW-1:0] roll_x;
    logic signed [CW-1:0] roll_y;
  } side_t;

  // round half up to output precision, then wrap into 0..360
  function automatic logic [15:0] finish(input logic signed [ZW+1:0] a);
    logic signed [ZW+1:0] r;
    r = (a + RHALF) >>> RS;
    if (r > FULL) begin
      r = r - FULL;
    end else if (r < 0) begin
      r = r + FULL;
      if (r < 0) begin
        r = r + FULL;
      end
    end
    return r[15:0];
  endfunction

  // configuration register
  logic [15:0] pole_thr;
  always_ff @(posedge clk) begin
    if (rst) begin
      pole_thr <= POLE_THR_RESET;
    end else if (cfg_valid) begin
      pole_thr <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // stage 0: capture the word
  logic     v0;
  quat_in_t q0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    q0 <= quat;
  end

  // stage 1: component products
  logic v1;
  logic signed [31:0] p_xx, p_yy, p_zz, p_ww, p_xw, p_yz, p_wy, p_zx, p_wz, p_xy;
  logic signed [15:0] x1, y1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    p_xx <= q0.quat_x * q0.quat_x;
    p_yy <= q0.quat_y * q0.quat_y;
    p_zz <= q0.quat_z * q0.quat_z;
    p_ww <= q0.quat_w * q0.quat_w;
    p_xw <= q0.quat_x * q0.quat_w;
    p_yz <= q0.quat_y * q0.quat_z;
    p_wy <= q0.quat_w * q0.quat_y;
    p_zx <= q0.quat_z * q0.quat_x;
    p_wz <= q0.quat_w * q0.quat_z;
    p_xy <= q0.quat_x * q0.quat_y;
    x1   <= q0.quat_x;
    y1   <= q0.quat_y;
  end

  // stage 2: norm, pole term, atan2 operands, clamped arcsine argument
  logic v2;
  logic [32:0] norm2;
  logic signed [32:0] pole2;
  logic signed [33:0] s_raw;
  logic signed [31:0] s_sat;
  side_t side2;
  assign s_raw = 34'(33'(p_xw) - 33'(p_yz)) <<< 1;
  always_comb begin
    if (s_raw > S_MAX) begin
      s_sat = 32'(S_MAX);
    end else if (s_raw < -S_MAX) begin
      s_sat = 32'(-S_MAX);
    end else begin
      s_sat = 32'(s_raw);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    norm2 <= {1'b0, p_xx} + {1'b0, p_yy} + {1'b0, p_zz} + {1'b0, p_ww};
    pole2 <= 33'(p_xw) - 33'(p_yz);
    side2.pcase  <= POLE_NONE;
    side2.s      <= s_sat;
    side2.half_x <= CW'(x1) <<< 15;
    side2.half_y <= CW'(y1) <<< 15;
    side2.yaw_y  <= (CW'(p_wy) + CW'(p_zx)) <<< 1;
    side2.yaw_x  <= ONE_Q30 - ((CW'(p_xx) + CW'(p_yy)) <<< 1);
    side2.roll_y <= (CW'(p_wz) + CW'(p_xy)) <<< 1;
    side2.roll_x <= ONE_Q30 - ((CW'(p_zz) + CW'(p_xx)) <<< 1);
  end

  // stage 3: threshold product and square of the arcsine argument
  logic v3;
  logic signed [49:0] lhs3, rhs3;
  logic [RAD_W-1:0] ss3;
  logic signed [63:0] ss_full;
  side_t side3;
  assign ss_full = side2.s * side2.s;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    lhs3  <= 50'(pole2) <<< 16;
    rhs3  <= signed'(50'(pole_thr) * 50'(norm2));
    ss3   <= ss_full[RAD_W-1:0];
    side3 <= side2;
  end

  // stage 4: pole decision and square root radicand
  logic v4;
  logic [RAD_W-1:0] rad4;
  side_t side_dec;
  side_t side4;
  always_comb begin
    side_dec = side3;
    if (lhs3 > rhs3) begin
      side_dec.pcase = POLE_NORTH;
    end else if (lhs3 < -rhs3) begin
      side_dec.pcase = POLE_SOUTH;
    end else begin
      side_dec.pcase = POLE_NONE;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    rad4  <= (RAD_W'(1) << 60) - ss3;
    side4 <= side_dec;
  end

  // square root, with the side data delayed alongside
  logic              v_sq;
  logic [ROOT_W-1:0] root;
  side_t             side_sq [SQ_STG];

  q2e_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v4),
    .radicand (rad4),
    .out_valid(v_sq),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    side_sq[0] <= side4;
    for (int k = 1; k < SQ_STG; k++) begin
      side_sq[k] <= side_sq[k-1];
    end
  end

  // pick the first CORDIC's operands: pole half angle or arcsine
  side_t sd;
  logic  pole_sel;
  logic signed [CW-1:0] a_x, a_y;
  assign sd       = side_sq[SQ_STG-1];
  assign pole_sel = sd.pcase != POLE_NONE;
  assign a_x      = pole_sel ? sd.half_x : CW'(root);
  assign a_y      = pole_sel ? sd.half_y : CW'(sd.s);

  logic va, vb, vc;
  logic signed [ZW-1:0] za, zb, zc;

  q2e_cordic u_cord_a (
    .clk(clk), .rst(rst), .in_valid(v_sq), .vec_x(a_x), .vec_y(a_y),
    .out_valid(va), .angle(za)
  );
  q2e_cordic u_cord_b (
    .clk(clk), .rst(rst), .in_valid(v_sq), .vec_x(sd.yaw_x), .vec_y(sd.yaw_y),
    .out_valid(vb), .angle(zb)
  );
  q2e_cordic u_cord_c (
    .clk(clk), .rst(rst), .in_valid(v_sq), .vec_x(sd.roll_x), .vec_y(sd.roll_y),
    .out_valid(vc), .angle(zc)
  );

  // delay the pole decision by the CORDIC latency
  pole_case_t pc_d [CORD_LAT];
  always_ff @(posedge clk) begin
    pc_d[0] <= sd.pcase;
    for (int k = 1; k < CORD_LAT; k++) begin
      pc_d[k] <= pc_d[k-1];
    end
  end

  // assemble angles and register the result word
  pole_case_t pc_f;
  logic signed [ZW+1:0] pitch_a, yaw_a, roll_a;
  assign pc_f = pc_d[CORD_LAT-1];
  always_comb begin
    case (pc_f)
      POLE_NORTH: begin
        pitch_a = RIGHT;
        yaw_a   = (ZW+2)'(za) <<< 1;
        roll_a  = '0;
      end
      POLE_SOUTH: begin
        pitch_a = -RIGHT;
        yaw_a   = -((ZW+2)'(za) <<< 1);
        roll_a  = '0;
      end
      default: begin
        pitch_a = (ZW+2)'(za);
        yaw_a   = (ZW+2)'(zb);
        roll_a  = (ZW+2)'(zc);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= va & vb & vc;
    end
    result.pitch_deg <= finish(pitch_a);
    result.yaw_deg   <= finish(yaw_a);
    result.roll_deg  <= finish(roll_a);
    result.pole_case <= pc_f;
  end

  // checks
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("done raised right after reset");
  a_case_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.pole_case != 2'b11)
    else $error("undefined pole case code");
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.pitch_deg <= 16'd46080 && result.yaw_deg <= 16'd46080 &&
              result.roll_deg <= 16'd46080))
    else $error("angle outside 0..360");
  a_pole_roll: assert property (@(posedge clk) disable iff (rst)
    (done && result.pole_case != 2'b00) |-> result.roll_deg == 16'd0)
    else $error("nonzero roll at a pole");

endmodule
